[design/i2c_lcd_command_sequencer_core_macros.svh]
// Assertion macros for the LCD command sequencer.
`ifndef I2C_LCD_COMMAND_SEQUENCER_CORE_MACROS_SVH
`define I2C_LCD_COMMAND_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTH
`define LCD_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LCD_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LCD_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define LCD_ASSERT_NXT(name, clk, rst, ante, cons, msg)
`endif

`endif

[design/i2clcd_pkg.sv]
// Shared types and constants of the LCD command sequencer.
`timescale 1ns / 1ps
package i2clcd_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int OUT_DEPTH   = 3;
  localparam int OUT_PTR_W   = 2;

  localparam logic [3:0] ACT_CLEAR     = 4'd0;
  localparam logic [3:0] ACT_BACKLIGHT = 4'd1;
  localparam logic [3:0] ACT_GET_ID    = 4'd2;
  localparam logic [3:0] ACT_GET_FW    = 4'd3;
  localparam logic [3:0] ACT_LOAD_CHAR = 4'd4;
  localparam logic [3:0] ACT_WRITE     = 4'd5;
  localparam logic [3:0] ACT_POLL      = 4'd6;
  localparam logic [3:0] ACT_TICK      = 4'd7;
  localparam logic [3:0] ACT_TX_DONE   = 4'd8;
  localparam logic [3:0] ACT_RX_DONE   = 4'd9;
  localparam logic [3:0] ACT_TIMER     = 4'd10;

  localparam logic [1:0] REPLY_NONE   = 2'd0;
  localparam logic [1:0] REPLY_ACCEPT = 2'd1;
  localparam logic [1:0] REPLY_BUSY   = 2'd2;
  localparam logic [1:0] REPLY_BUS_ERR = 2'd3;

  localparam logic [1:0] BUS_NONE  = 2'd0;
  localparam logic [1:0] BUS_WRITE = 2'd1;
  localparam logic [1:0] BUS_READ  = 2'd2;

  localparam logic [7:0] CODE_BUTTONS  = 8'h05;
  localparam logic [7:0] CODE_ID       = 8'h20;
  localparam logic [7:0] CODE_FIRMWARE = 8'h21;
  localparam logic [7:0] CODE_CLEAR    = 8'h60;
  localparam logic [7:0] CODE_TEXT     = 8'h61;
  localparam logic [7:0] CODE_LIGHT    = 8'h62;

  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FIRST_DELAY    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_DELAY   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CLEAR_DELAY    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_POLL_INTERVAL  = 3'd4;

  localparam logic [15:0] RST_FIRST_DELAY   = 16'd2000;
  localparam logic [11:0] RST_COLUMN_DELAY  = 12'd1000;
  localparam logic [15:0] RST_CLEAR_DELAY   = 16'd50000;
  localparam logic [15:0] RST_POLL_INTERVAL = 16'd100;

  typedef struct packed {
    logic [3:0] action;
    logic       bus_ok;
    logic [7:0] data_byte;
    logic [3:0] char_index;
    logic [4:0] text_length;
    logic [7:0] column;
    logic [7:0] row;
  } item_t;

  typedef struct packed {
    logic [1:0]  reply;
    logic [1:0]  bus_op;
    logic [2:0]  bus_length;
    logic [7:0]  bus_byte0;
    logic [7:0]  bus_byte1;
    logic [7:0]  bus_byte2;
    logic [7:0]  bus_byte3;
    logic        timer_arm;
    logic [20:0] timer_delay;
    logic [7:0]  button_state;
    logic [7:0]  board_id;
    logic [7:0]  firmware_id;
  } result_t;

endpackage

[design/i2clcd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module i2clcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/i2clcd_out_fifo.sv]
// Three-entry result queue between the sequencer and the output channel.
`timescale 1ns / 1ps
module i2clcd_out_fifo (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  i2clcd_pkg::result_t             push_data,
  input  logic                            pop,
  output i2clcd_pkg::result_t             head,
  output logic [i2clcd_pkg::OUT_PTR_W-1:0] count
);
  import i2clcd_pkg::*;

  result_t              entries [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_PTR_W-1:0] wr_ptr_next;
  logic [OUT_PTR_W-1:0] rd_ptr_next;

  assign wr_ptr_next = (wr_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr + OUT_PTR_W'(1);
  assign rd_ptr_next = (rd_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr + OUT_PTR_W'(1);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (pop) begin
        rd_ptr <= rd_ptr_next;
      end
      if (push && !pop) begin
        count <= count + OUT_PTR_W'(1);
      end else if (pop && !push) begin
        count <= count - OUT_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[design/i2clcd_ctrl.sv]
// Command state, event handling and text store of the LCD sequencer.
`timescale 1ns / 1ps
module i2clcd_ctrl #(
  parameter int LINE_CHARS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              take,
  input  i2clcd_pkg::item_t                 item,
  input  logic                              cfg_write,
  input  logic [i2clcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [i2clcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                              stage_valid,
  output i2clcd_pkg::result_t               stage_res
);
  import i2clcd_pkg::*;

  localparam int AW = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam int CW = $clog2(LINE_CHARS + 1);
  localparam logic [6:0] LINE_LEN = 7'(LINE_CHARS);

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_BUTTON,
    CMD_ID,
    CMD_FIRMWARE,
    CMD_CLEAR,
    CMD_WRITE,
    CMD_LIGHT
  } cmd_t;

  cmd_t        cmd, cmd_next;
  logic [AW-1:0] send_index, send_index_next;
  logic [CW-1:0] chars_left, chars_left_next;
  logic [7:0]  cur_row, cur_row_next;
  logic [7:0]  cur_column, cur_column_next;
  logic        poll_pending, poll_pending_next;
  logic [31:0] ms_now, ms_now_next;
  logic [31:0] next_poll_time, next_poll_time_next;
  logic [7:0]  buttons_reg, buttons_reg_next;
  logic [7:0]  ident_reg, ident_reg_next;
  logic [7:0]  firmware_reg, firmware_reg_next;

  logic [15:0] first_delay;
  logic [11:0] column_delay;
  logic [15:0] clear_delay;
  logic [15:0] poll_interval;

  result_t     res_next;
  result_t     s_res;
  logic        use_ram_next;
  logic        s_use_ram;
  logic        poll_try;
  logic        ram_we;
  logic        ram_re;
  logic [AW-1:0] ram_raddr;
  logic [AW-1:0] ram_waddr;
  logic [7:0]  ram_rdata;

  logic        idle;
  logic        ok;
  logic        too_early;
  logic [6:0]  index_w;
  logic [6:0]  len_w;
  logic [6:0]  len_clamped;
  logic [19:0] column_prod;
  logic [20:0] write_delay;

  assign idle        = (cmd == CMD_IDLE);
  assign ok          = item.bus_ok;
  assign too_early   = (next_poll_time > ms_now);
  assign index_w     = 7'(item.char_index);
  assign ram_waddr   = index_w[AW-1:0];
  assign len_w       = 7'(item.text_length);
  assign len_clamped = (len_w == 7'd0) ? 7'd1 : ((len_w > LINE_LEN) ? LINE_LEN : len_w);
  assign column_prod = 20'(column_delay) * 20'(cur_column);
  assign write_delay = 21'(first_delay) + 21'(column_prod);

  always_comb begin
    cmd_next            = cmd;
    send_index_next     = send_index;
    chars_left_next     = chars_left;
    cur_row_next        = cur_row;
    cur_column_next     = cur_column;
    poll_pending_next   = poll_pending;
    ms_now_next         = ms_now;
    next_poll_time_next = next_poll_time;
    buttons_reg_next    = buttons_reg;
    ident_reg_next      = ident_reg;
    firmware_reg_next   = firmware_reg;
    res_next            = '0;
    use_ram_next        = 1'b0;
    poll_try            = 1'b0;
    ram_we              = 1'b0;
    ram_re              = 1'b0;
    ram_raddr           = '0;

    unique case (item.action)
      ACT_CLEAR, ACT_BACKLIGHT, ACT_GET_ID, ACT_GET_FW: begin
        if (!idle) begin
          res_next.reply = REPLY_BUSY;
        end else if (!ok) begin
          res_next.reply = REPLY_BUS_ERR;
        end else begin
          res_next.reply      = REPLY_ACCEPT;
          res_next.bus_op     = BUS_WRITE;
          res_next.bus_length = 3'd1;
          unique case (item.action)
            ACT_CLEAR: begin
              cmd_next           = CMD_CLEAR;
              res_next.bus_byte0 = CODE_CLEAR;
            end
            ACT_BACKLIGHT: begin
              cmd_next            = CMD_LIGHT;
              res_next.bus_byte0  = CODE_LIGHT;
              res_next.bus_byte1  = item.data_byte;
              res_next.bus_length = 3'd2;
            end
            ACT_GET_ID: begin
              cmd_next           = CMD_ID;
              res_next.bus_byte0 = CODE_ID;
            end
            default: begin
              cmd_next           = CMD_FIRMWARE;
              res_next.bus_byte0 = CODE_FIRMWARE;
            end
          endcase
        end
      end
      ACT_LOAD_CHAR: begin
        if (cmd == CMD_WRITE) begin
          res_next.reply = REPLY_BUSY;
        end else begin
          res_next.reply = REPLY_ACCEPT;
          ram_we         = (index_w < LINE_LEN);
        end
      end
      ACT_WRITE: begin
        if (!idle) begin
          res_next.reply = REPLY_BUSY;
        end else if (!ok) begin
          res_next.reply = REPLY_BUS_ERR;
        end else begin
          cmd_next            = CMD_WRITE;
          send_index_next     = '0;
          chars_left_next     = len_clamped[CW-1:0];
          cur_row_next        = item.row;
          cur_column_next     = item.column;
          res_next.reply      = REPLY_ACCEPT;
          res_next.bus_op     = BUS_WRITE;
          res_next.bus_length = 3'd4;
          res_next.bus_byte0  = CODE_TEXT;
          res_next.bus_byte1  = item.row;
          res_next.bus_byte2  = item.column;
          ram_re              = 1'b1;
          ram_raddr           = '0;
          use_ram_next        = 1'b1;
        end
      end
      ACT_POLL: begin
        if (too_early) begin
          res_next.reply = REPLY_BUSY;
        end else if (!idle) begin
          poll_pending_next = 1'b1;
          res_next.reply    = REPLY_BUSY;
        end else begin
          poll_try = 1'b1;
        end
      end
      ACT_TICK: begin
        ms_now_next = ms_now + 32'd1;
      end
      ACT_TX_DONE: begin
        res_next.timer_arm   = 1'b1;
        res_next.timer_delay = 21'(first_delay);
        unique case (cmd)
          CMD_CLEAR: begin
            res_next.timer_delay = 21'(clear_delay);
          end
          CMD_BUTTON, CMD_ID, CMD_FIRMWARE: begin
            if (ok) begin
              res_next.timer_arm   = 1'b0;
              res_next.timer_delay = '0;
              res_next.bus_op      = BUS_READ;
            end
          end
          CMD_WRITE: begin
            res_next.timer_delay = write_delay;
          end
          default: begin
          end
        endcase
      end
      ACT_RX_DONE: begin
        res_next.timer_arm   = 1'b1;
        res_next.timer_delay = 21'(first_delay);
        unique case (cmd)
          CMD_BUTTON:   buttons_reg_next  = ~item.data_byte;
          CMD_ID:       ident_reg_next    = item.data_byte;
          CMD_FIRMWARE: firmware_reg_next = item.data_byte;
          default: begin
          end
        endcase
      end
      ACT_TIMER: begin
        if ((cmd == CMD_WRITE) && (chars_left > CW'(1))) begin
          chars_left_next = chars_left - CW'(1);
          send_index_next = send_index + AW'(1);
          cur_column_next = cur_column + 8'd1;
          if (ok) begin
            res_next.bus_op     = BUS_WRITE;
            res_next.bus_length = 3'd4;
            res_next.bus_byte0  = CODE_TEXT;
            res_next.bus_byte1  = cur_row;
            res_next.bus_byte2  = cur_column + 8'd1;
            ram_re              = 1'b1;
            ram_raddr           = send_index + AW'(1);
            use_ram_next        = 1'b1;
          end else begin
            chars_left_next      = CW'(1);
            res_next.timer_arm   = 1'b1;
            res_next.timer_delay = 21'(first_delay);
          end
        end else begin
          if (cmd == CMD_WRITE) begin
            chars_left_next = '0;
          end
          cmd_next = CMD_IDLE;
          if (poll_pending) begin
            if (too_early) begin
              res_next.reply = REPLY_BUSY;
            end else begin
              poll_try = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (poll_try) begin
      if (!ok) begin
        res_next.reply = REPLY_BUS_ERR;
      end else begin
        cmd_next            = CMD_BUTTON;
        poll_pending_next   = 1'b0;
        next_poll_time_next = ms_now + 32'(poll_interval);
        res_next.reply      = REPLY_ACCEPT;
        res_next.bus_op     = BUS_WRITE;
        res_next.bus_length = 3'd1;
        res_next.bus_byte0  = CODE_BUTTONS;
      end
    end

    res_next.button_state = buttons_reg_next;
    res_next.board_id     = ident_reg_next;
    res_next.firmware_id  = firmware_reg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd            <= CMD_IDLE;
      send_index     <= '0;
      chars_left     <= '0;
      cur_row        <= '0;
      cur_column     <= '0;
      poll_pending   <= 1'b0;
      ms_now         <= '0;
      next_poll_time <= '0;
      buttons_reg    <= '0;
      ident_reg      <= '0;
      firmware_reg   <= '0;
      stage_valid    <= 1'b0;
      first_delay    <= RST_FIRST_DELAY;
      column_delay   <= RST_COLUMN_DELAY;
      clear_delay    <= RST_CLEAR_DELAY;
      poll_interval  <= RST_POLL_INTERVAL;
    end else begin
      stage_valid <= take;
      if (take) begin
        cmd            <= cmd_next;
        send_index     <= send_index_next;
        chars_left     <= chars_left_next;
        cur_row        <= cur_row_next;
        cur_column     <= cur_column_next;
        poll_pending   <= poll_pending_next;
        ms_now         <= ms_now_next;
        next_poll_time <= next_poll_time_next;
        buttons_reg    <= buttons_reg_next;
        ident_reg      <= ident_reg_next;
        firmware_reg   <= firmware_reg_next;
      end
      if (cfg_write) begin
        unique case (cfg_index)
          REG_DEVICE_ADDRESS: begin
          end
          REG_FIRST_DELAY:   first_delay   <= cfg_data;
          REG_COLUMN_DELAY:  column_delay  <= cfg_data[11:0];
          REG_CLEAR_DELAY:   clear_delay   <= cfg_data;
          REG_POLL_INTERVAL: poll_interval <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_res     <= res_next;
      s_use_ram <= use_ram_next;
    end
  end

  i2clcd_ram #(
    .WIDTH(8),
    .DEPTH(LINE_CHARS)
  ) u_text_ram (
    .clk   (clk),
    .we    (take && ram_we),
    .waddr (ram_waddr),
    .wdata (item.data_byte),
    .re    (take && ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    stage_res = s_res;
    if (s_use_ram) begin
      stage_res.bus_byte3 = ram_rdata;
    end
  end

endmodule

[design/i2c_lcd_command_sequencer_core.sv]
// Top level of the I2C LCD command sequencer.
`timescale 1ns / 1ps
// Takes one request or bus event per clock cycle and gives exactly one result
// transaction for each. The accepting cycle updates the command state and
// issues the text RAM read; the staged result then takes the registered character
// byte into the queue. A three-entry result queue keeps input accepting while
// results wait, so a stalled output throttles the input once queued and staged
// results fill it. The text store needs no clearing after reset; the block
// accepts transactions from the first cycle after reset.
module i2c_lcd_command_sequencer_core #(
  parameter int LINE_CHARS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  action,
  input  logic        bus_ok,
  input  logic [7:0]  data_byte,
  input  logic [3:0]  char_index,
  input  logic [4:0]  text_length,
  input  logic [7:0]  column,
  input  logic [7:0]  row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  reply,
  output logic [1:0]  bus_op,
  output logic [2:0]  bus_length,
  output logic [7:0]  bus_byte0,
  output logic [7:0]  bus_byte1,
  output logic [7:0]  bus_byte2,
  output logic [7:0]  bus_byte3,
  output logic        timer_arm,
  output logic [20:0] timer_delay,
  output logic [7:0]  button_state,
  output logic [7:0]  board_id,
  output logic [7:0]  firmware_id,
  input  logic        cfg_write,
  input  logic [i2clcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [i2clcd_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import i2clcd_pkg::*;

`include "i2c_lcd_command_sequencer_core_macros.svh"

  item_t                item;
  logic                 take;
  logic                 stage_valid;
  result_t              stage_res;
  result_t              head;
  logic [OUT_PTR_W-1:0] fifo_count;
  logic                 pop;

  assign item.action      = action;
  assign item.bus_ok      = bus_ok;
  assign item.data_byte   = data_byte;
  assign item.char_index  = char_index;
  assign item.text_length = text_length;
  assign item.column      = column;
  assign item.row         = row;

  assign in_ready  = ((3'(fifo_count) + 3'(stage_valid)) <= 3'(OUT_DEPTH - 1));
  assign take      = in_valid && in_ready;
  assign out_valid = (fifo_count != '0);
  assign pop       = out_valid && out_ready;

  i2clcd_ctrl #(
    .LINE_CHARS(LINE_CHARS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .item        (item),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .stage_valid (stage_valid),
    .stage_res   (stage_res)
  );

  i2clcd_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (stage_valid),
    .push_data (stage_res),
    .pop       (pop),
    .head      (head),
    .count     (fifo_count)
  );

  assign reply        = head.reply;
  assign bus_op       = head.bus_op;
  assign bus_length   = head.bus_length;
  assign bus_byte0    = head.bus_byte0;
  assign bus_byte1    = head.bus_byte1;
  assign bus_byte2    = head.bus_byte2;
  assign bus_byte3    = head.bus_byte3;
  assign timer_arm    = head.timer_arm;
  assign timer_delay  = head.timer_delay;
  assign button_state = head.button_state;
  assign board_id     = head.board_id;
  assign firmware_id  = head.firmware_id;

  `LCD_ASSERT_NXT(a_take_reaches_stage, clk, rst, take, stage_valid, "accepted transaction lost before queue")
  `LCD_ASSERT_IMP(a_no_queue_overflow, clk, rst, stage_valid, fifo_count != OUT_PTR_W'(OUT_DEPTH), "result pushed into full queue")
  `LCD_ASSERT_IMP(a_idle_bus_quiet, clk, rst, stage_valid && (stage_res.bus_op != BUS_WRITE), stage_res.bus_length == 3'd0, "length set without write transfer")

endmodule

[dv/i2c_lcd_command_sequencer_core_test.sv]
// Self-checking testbench for the I2C LCD command sequencer core with a built-in predictor.
`timescale 1ns / 1ps
module i2c_lcd_command_sequencer_core_test;
  import i2clcd_pkg::*;

  localparam int LINE_CHARS   = 16;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int STALL_CYCLES = 300;
  localparam int PHASE_ITEMS  = 375;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_BUTTON, SEQ_ID, SEQ_FIRMWARE, SEQ_CLEAR, SEQ_WRITE, SEQ_LIGHT
  } seq_cmd_t;

  class lcd_sequencer_tracker;
    logic [7:0]  dev_addr;
    logic [15:0] first_delay, clear_delay_us, poll_interval;
    logic [11:0] column_delay;
    seq_cmd_t    active;
    logic [7:0]  text [LINE_CHARS];
    logic [3:0]  slot;
    logic [4:0]  remaining;
    logic [7:0]  line_row, line_col, level;
    logic        poll_waiting;
    logic [31:0] ms_count, poll_due;
    logic [7:0]  buttons, board, firmware;
    result_t     pending_results[$];
    int unsigned error_count, checked_count;

    function new();
      dev_addr = 8'd96;
      first_delay = RST_FIRST_DELAY;
      column_delay = RST_COLUMN_DELAY;
      clear_delay_us = RST_CLEAR_DELAY;
      poll_interval = RST_POLL_INTERVAL;
      active = SEQ_IDLE;
      foreach (text[i]) text[i] = '0;
      slot = '0; remaining = '0; line_row = '0; line_col = '0; level = '0;
      poll_waiting = 1'b0; ms_count = '0; poll_due = '0;
      buttons = '0; board = '0; firmware = '0;
      error_count = 0; checked_count = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_DEVICE_ADDRESS: dev_addr = data[7:0];
        REG_FIRST_DELAY:    first_delay = data;
        REG_COLUMN_DELAY:   column_delay = data[11:0];
        REG_CLEAR_DELAY:    clear_delay_us = data;
        REG_POLL_INTERVAL:  poll_interval = data;
        default: ;
      endcase
    endfunction

    function void put_write(inout result_t r, input logic [2:0] len,
                            input logic [7:0] b0, b1, b2, b3);
      r.bus_op = BUS_WRITE;
      r.bus_length = len;
      r.bus_byte0 = b0;
      r.bus_byte1 = b1;
      r.bus_byte2 = b2;
      r.bus_byte3 = b3;
    endfunction

    function void load_timer(inout result_t r, input logic [31:0] us);
      r.timer_arm = 1'b1;
      r.timer_delay = us[20:0];
    endfunction

    function logic [1:0] start_request(inout result_t r, input seq_cmd_t cmd,
                                       input logic [7:0] code, input logic [2:0] len,
                                       input logic [7:0] b1, input logic ok);
      if (active != SEQ_IDLE) return REPLY_BUSY;
      if (!ok) return REPLY_BUS_ERR;
      active = cmd;
      put_write(r, len, code, b1, 8'd0, 8'd0);
      return REPLY_ACCEPT;
    endfunction

    function logic [1:0] try_button_poll(inout result_t r, input logic ok);
      if (poll_due > ms_count) return REPLY_BUSY;
      if (active != SEQ_IDLE) begin
        poll_waiting = 1'b1;
        return REPLY_BUSY;
      end
      if (!ok) return REPLY_BUS_ERR;
      active = SEQ_BUTTON;
      put_write(r, 3'd1, CODE_BUTTONS, 8'd0, 8'd0, 8'd0);
      poll_waiting = 1'b0;
      poll_due = ms_count + 32'(poll_interval);
      return REPLY_ACCEPT;
    endfunction

    function void take_request(item_t it);
      result_t    r;
      logic [1:0] answer;
      logic [4:0] n;
      r = '0;
      answer = REPLY_NONE;
      case (it.action)
        ACT_CLEAR:
          answer = start_request(r, SEQ_CLEAR, CODE_CLEAR, 3'd1, 8'd0, it.bus_ok);
        ACT_BACKLIGHT: begin
          answer = start_request(r, SEQ_LIGHT, CODE_LIGHT, 3'd2, it.data_byte, it.bus_ok);
          if (answer == REPLY_ACCEPT) level = it.data_byte;
        end
        ACT_GET_ID:
          answer = start_request(r, SEQ_ID, CODE_ID, 3'd1, 8'd0, it.bus_ok);
        ACT_GET_FW:
          answer = start_request(r, SEQ_FIRMWARE, CODE_FIRMWARE, 3'd1, 8'd0, it.bus_ok);
        ACT_LOAD_CHAR: begin
          if (active == SEQ_WRITE) begin
            answer = REPLY_BUSY;
          end else begin
            text[it.char_index] = it.data_byte;
            answer = REPLY_ACCEPT;
          end
        end
        ACT_WRITE: begin
          if (active != SEQ_IDLE) begin
            answer = REPLY_BUSY;
          end else if (!it.bus_ok) begin
            answer = REPLY_BUS_ERR;
          end else begin
            n = it.text_length;
            if (n == 0) n = 5'd1;
            if (n > LINE_CHARS) n = 5'(LINE_CHARS);
            active = SEQ_WRITE;
            slot = '0;
            remaining = n;
            line_row = it.row;
            line_col = it.column;
            put_write(r, 3'd4, CODE_TEXT, line_row, line_col, text[0]);
            answer = REPLY_ACCEPT;
          end
        end
        ACT_POLL: answer = try_button_poll(r, it.bus_ok);
        ACT_TICK: ms_count = ms_count + 32'd1;
        ACT_TX_DONE: begin
          case (active)
            SEQ_CLEAR: load_timer(r, 32'(clear_delay_us));
            SEQ_BUTTON, SEQ_ID, SEQ_FIRMWARE: begin
              if (it.bus_ok) r.bus_op = BUS_READ;
              else load_timer(r, 32'(first_delay));
            end
            SEQ_WRITE:
              load_timer(r, 32'(first_delay) + 32'(column_delay) * 32'(line_col));
            default: load_timer(r, 32'(first_delay));
          endcase
        end
        ACT_RX_DONE: begin
          if (active == SEQ_BUTTON) buttons = ~it.data_byte;
          else if (active == SEQ_ID) board = it.data_byte;
          else if (active == SEQ_FIRMWARE) firmware = it.data_byte;
          load_timer(r, 32'(first_delay));
        end
        ACT_TIMER: begin
          if (active == SEQ_WRITE && remaining > 1) begin
            remaining = remaining - 5'd1;
            slot = slot + 4'd1;
            line_col = line_col + 8'd1;
            if (it.bus_ok) begin
              put_write(r, 3'd4, CODE_TEXT, line_row, line_col, text[slot]);
            end else begin
              remaining = 5'd1;
              load_timer(r, 32'(first_delay));
            end
          end else begin
            if (active == SEQ_WRITE) remaining = '0;
            active = SEQ_IDLE;
          end
          if (active == SEQ_IDLE && poll_waiting) answer = try_button_poll(r, it.bus_ok);
        end
        default: ;
      endcase
      r.reply = answer;
      r.button_state = buttons;
      r.board_id = board;
      r.firmware_id = firmware;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        error_count++;
      end
    endfunction

    function void compare_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        error_count++;
        return;
      end
      want = pending_results.pop_front();
      checked_count++;
      compare_field("reply", want.reply, got.reply);
      compare_field("bus_op", want.bus_op, got.bus_op);
      compare_field("bus_length", want.bus_length, got.bus_length);
      compare_field("bus_byte0", want.bus_byte0, got.bus_byte0);
      compare_field("bus_byte1", want.bus_byte1, got.bus_byte1);
      compare_field("bus_byte2", want.bus_byte2, got.bus_byte2);
      compare_field("bus_byte3", want.bus_byte3, got.bus_byte3);
      compare_field("timer_arm", want.timer_arm, got.timer_arm);
      compare_field("timer_delay", want.timer_delay, got.timer_delay);
      compare_field("button_state", want.button_state, got.button_state);
      compare_field("board_id", want.board_id, got.board_id);
      compare_field("firmware_id", want.firmware_id, got.firmware_id);
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  action = '0;
  logic        bus_ok = 1'b0;
  logic [7:0]  data_byte = '0;
  logic [3:0]  char_index = '0;
  logic [4:0]  text_length = '0;
  logic [7:0]  column = '0;
  logic [7:0]  row = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  reply;
  logic [1:0]  bus_op;
  logic [2:0]  bus_length;
  logic [7:0]  bus_byte0, bus_byte1, bus_byte2, bus_byte3;
  logic        timer_arm;
  logic [20:0] timer_delay;
  logic [7:0]  button_state, board_id, firmware_id;
  logic        cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  lcd_sequencer_tracker sb = new();
  bit          gaps_on = 1'b1;
  bit          stall_req = 1'b0;
  bit          stall_done = 1'b0;
  int          stall_left = 0;
  int unsigned sent_count = 0;
  int unsigned cycle_count = 0;

  i2c_lcd_command_sequencer_core #(.LINE_CHARS(LINE_CHARS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .bus_ok(bus_ok), .data_byte(data_byte), .char_index(char_index),
    .text_length(text_length), .column(column), .row(row),
    .out_valid(out_valid), .out_ready(out_ready),
    .reply(reply), .bus_op(bus_op), .bus_length(bus_length),
    .bus_byte0(bus_byte0), .bus_byte1(bus_byte1), .bus_byte2(bus_byte2),
    .bus_byte3(bus_byte3), .timer_arm(timer_arm), .timer_delay(timer_delay),
    .button_state(button_state), .board_id(board_id), .firmware_id(firmware_id),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.take_request(item_t'({action, bus_ok, data_byte, char_index, text_length,
                               column, row}));
    if (!rst && out_valid && out_ready)
      sb.compare_result(result_t'({reply, bus_op, bus_length, bus_byte0, bus_byte1,
                                   bus_byte2, bus_byte3, timer_arm, timer_delay,
                                   button_state, board_id, firmware_id}));
  end

  // hold off the output once for a long stretch, otherwise stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (stall_req && !stall_done) begin
        stall_left = STALL_CYCLES;
        stall_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(gaps_on && $urandom_range(0, 99) < 11);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("i2c_lcd_command_sequencer_core_test failed");
    $finish;
  end

  function automatic item_t mk(logic [3:0] act, logic ok, logic [7:0] data,
                               logic [3:0] idx, logic [4:0] len, logic [7:0] col,
                               logic [7:0] rw);
    item_t it;
    it.action = act;
    it.bus_ok = ok;
    it.data_byte = data;
    it.char_index = idx;
    it.text_length = len;
    it.column = col;
    it.row = rw;
    return it;
  endfunction

  function automatic item_t fresh(logic [3:0] act);
    return mk(act, $urandom_range(0, 99) < 90, 8'($urandom), 4'($urandom),
              5'($urandom_range(0, 16)), 8'($urandom), 8'($urandom));
  endfunction

  task automatic send_item(input item_t it);
    if (gaps_on && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 11);
    end
    action <= it.action;
    bus_ok <= it.bus_ok;
    data_byte <= it.data_byte;
    char_index <= it.char_index;
    text_length <= it.text_length;
    column <= it.column;
    row <= it.row;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sent_count++;
  endtask

  // occasionally slip a random transaction in before the intended one
  task automatic step(input logic [3:0] act);
    if ($urandom_range(0, 99) < 8) send_item(fresh(4'($urandom_range(ACT_CLEAR, ACT_TIMER))));
    send_item(fresh(act));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    sb.set_reg(index, data);
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] addr, first, coldelay, clr, poll);
    write_reg(REG_DEVICE_ADDRESS, addr);
    write_reg(REG_FIRST_DELAY, first);
    write_reg(REG_COLUMN_DELAY, coldelay);
    write_reg(REG_CLEAR_DELAY, clr);
    write_reg(REG_POLL_INTERVAL, poll);
    cfg_write <= 1'b0;
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    item_t       it;
    stop_at = sent_count + count;
    while (sent_count < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        it = fresh(ACT_WRITE);
        if ($urandom_range(0, 99) < 80) it.text_length = 5'($urandom_range(0, 4));
        if ($urandom_range(0, 99) < 25) it.column = 8'($urandom_range(248, 255));
        send_item(it);
        n = (it.text_length == 0) ? 1 : it.text_length;
        repeat (n) begin
          step(ACT_TX_DONE);
          step(ACT_TIMER);
        end
      end else if (pick < 45) begin
        step($urandom_range(0, 1) ? ACT_GET_ID : ACT_GET_FW);
        step(ACT_TX_DONE);
        step(ACT_RX_DONE);
        step(ACT_TIMER);
      end else if (pick < 55) begin
        step($urandom_range(0, 1) ? ACT_CLEAR : ACT_BACKLIGHT);
        step(ACT_TX_DONE);
        step(ACT_TIMER);
      end else if (pick < 70) begin
        repeat ($urandom_range(0, 12)) step(ACT_TICK);
        step(ACT_POLL);
        step(ACT_TX_DONE);
        step(ACT_RX_DONE);
        step(ACT_TIMER);
      end else if (pick < 78) begin
        // poll while busy, then let the timer expiry launch the deferred poll
        repeat ($urandom_range(0, 6)) step(ACT_TICK);
        step($urandom_range(0, 1) ? ACT_GET_ID : ACT_GET_FW);
        step(ACT_POLL);
        repeat (2) begin
          step(ACT_TX_DONE);
          step(ACT_RX_DONE);
          step(ACT_TIMER);
        end
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 3)) step(ACT_LOAD_CHAR);
      end else begin
        repeat ($urandom_range(1, 4)) send_item(fresh(4'($urandom_range(ACT_CLEAR, ACT_TIMER))));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the text store so that no write reads an empty slot
    for (int i = 0; i < LINE_CHARS; i++)
      send_item(mk(ACT_LOAD_CHAR, 1'b1, 8'($urandom), 4'(i), 5'd0, 8'd0, 8'd0));

    send_item(mk(ACT_CLEAR, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_TX_DONE, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_TIMER, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_BACKLIGHT, 1'b1, 8'hFF, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_TX_DONE, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_TIMER, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_GET_ID, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_TX_DONE, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_RX_DONE, 1'b1, 8'hA5, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_TIMER, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_GET_FW, 1'b0, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_WRITE, 1'b1, 8'h00, 4'd0, 5'd2, 8'hFF, 8'hFF));
    send_item(mk(ACT_LOAD_CHAR, 1'b1, 8'h00, 4'd15, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_TX_DONE, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_TIMER, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_TX_DONE, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_TIMER, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_POLL, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_TX_DONE, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_RX_DONE, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_TIMER, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_POLL, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_TX_DONE, 1'b1, 8'h00, 4'd0, 5'd0, 8'h00, 8'h00));
    send_item(mk(ACT_RX_DONE, 1'b1, 8'hFF, 4'd0, 5'd0, 8'h00, 8'h00));

    settle();
    program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_random(PHASE_ITEMS);

    settle();
    gaps_on = 1'b0;
    program_regs(16'($urandom_range(0, 255)), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom_range(1, 8)));
    run_random(PHASE_ITEMS);

    settle();
    gaps_on = 1'b1;
    program_regs(16'd96, RST_FIRST_DELAY, 16'(RST_COLUMN_DELAY), RST_CLEAR_DELAY,
                 RST_POLL_INTERVAL);
    stall_req = 1'b1;
    run_random(PHASE_ITEMS);

    settle();
    program_regs(16'h00FF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(PHASE_ITEMS);

    settle();
    if (sb.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_results.size());
      sb.error_count++;
    end
    $display("Sent %0d request transactions, checked %0d results, %0d mismatches",
             sent_count, sb.checked_count, sb.error_count);
    $display("Settings ran from all-zero to all-ones, with a %0d-cycle output hold-off",
             STALL_CYCLES);
    if (sb.error_count == 0)
      $display("i2c_lcd_command_sequencer_core_test passed");
    else
      $display("i2c_lcd_command_sequencer_core_test failed");
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/i2clcd_pkg.sv
design/i2clcd_ram.sv
design/i2clcd_out_fifo.sv
design/i2clcd_ctrl.sv
design/i2c_lcd_command_sequencer_core.sv
dv/i2c_lcd_command_sequencer_core_test.sv
